[rtl/cwdd_pkg.sv]
package cwdd_pkg;

    // Default width of the weight fields, in bits.
    localparam int DEFAULT_WEIGHT_BITS = 20;

    // Fixed field widths.
    localparam int THRESH_BITS  = 19;
    localparam int TIME_BITS    = 32;
    localparam int DELTA_BITS   = 20;
    localparam int AMOUNT_BITS  = 21;
    localparam int KIND_BITS    = 2;
    localparam int MODE_BITS    = 3;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 32;

    // Largest magnitude of a reported amount.
    localparam logic [AMOUNT_BITS-1:0] AMOUNT_MAX = 21'd1048575;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_CUP_THRESH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIFT_TMO   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_DELTA  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DELTA  = 2'd3;

    // Configuration reset values.
    localparam logic [THRESH_BITS-1:0] RST_CUP_THRESH = 19'd500;
    localparam logic [TIME_BITS-1:0]   RST_LIFT_TMO   = 32'd30000;
    localparam logic [DELTA_BITS-1:0]  RST_MIN_DELTA  = 20'd100;
    localparam logic [DELTA_BITS-1:0]  RST_MAX_DELTA  = 20'd10000;

    // Event codes.
    localparam logic [KIND_BITS-1:0] EVT_NONE   = 2'd0;
    localparam logic [KIND_BITS-1:0] EVT_DRINK  = 2'd1;
    localparam logic [KIND_BITS-1:0] EVT_REFILL = 2'd2;

    // Mode codes as seen on the result.
    localparam logic [MODE_BITS-1:0] MODE_CODE_NO_CUP   = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_CODE_UNSTABLE = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_CODE_STABLE   = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_CODE_POSSIBLE = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_CODE_DRINK    = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_CODE_REFILL   = 3'd5;

endpackage

[rtl/cwdd_sample_if.sv]
interface cwdd_sample_if
    import cwdd_pkg::*;
#(
    parameter int WEIGHT_BITS = DEFAULT_WEIGHT_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [WEIGHT_BITS-1:0] weight_now;
    logic                          scale_settled;
    logic signed [WEIGHT_BITS-1:0] settled_weight;
    logic [TIME_BITS-1:0]          now_ms;

    modport source (output valid, weight_now, scale_settled, settled_weight, now_ms,
                    input ready);
    modport sink   (input valid, weight_now, scale_settled, settled_weight, now_ms,
                    output ready);
endinterface

[rtl/cwdd_result_if.sv]
interface cwdd_result_if
    import cwdd_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic [KIND_BITS-1:0]          event_kind;
    logic signed [AMOUNT_BITS-1:0] event_amount;
    logic [MODE_BITS-1:0]          mode_now;

    modport source (output valid, event_kind, event_amount, mode_now, input ready);
    modport sink   (input valid, event_kind, event_amount, mode_now, output ready);
endinterface

[rtl/cup_weight_drink_detector_unit.sv]
// Cup weight drink detector. Each sample transaction on i_sample yields exactly one
// result transaction on o_result, in order. A sample is captured into an input register,
// the mode update and the drink/refill decision are made in combinational compare and
// subtract logic, and the result is held in an output register: one sample per clock
// cycle is sustained while o_result.ready stays high.
// The input stays ready while a result waits, as long as the input register is
// free. Configuration registers are written through i_cfg_we/i_cfg_index/i_cfg_data and
// must only be changed while no transaction is in flight.
module cup_weight_drink_detector_unit
    import cwdd_pkg::*;
#(
    parameter int WEIGHT_BITS = DEFAULT_WEIGHT_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    cwdd_sample_if.sink              i_sample,
    cwdd_result_if.source            o_result,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // Widths for the presence compare (CW) and for the delta arithmetic (DW).
    localparam int CW = ((WEIGHT_BITS > DELTA_BITS) ? WEIGHT_BITS : DELTA_BITS) + 1;
    localparam int DW = ((WEIGHT_BITS + 1 > AMOUNT_BITS) ? WEIGHT_BITS + 1 : AMOUNT_BITS) + 1;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_NO_CUP   = MODE_CODE_NO_CUP,
        MODE_UNSTABLE = MODE_CODE_UNSTABLE,
        MODE_STABLE   = MODE_CODE_STABLE,
        MODE_POSSIBLE = MODE_CODE_POSSIBLE,
        MODE_DRINK    = MODE_CODE_DRINK,
        MODE_REFILL   = MODE_CODE_REFILL
    } t_mode;

    // Configuration.
    logic [THRESH_BITS-1:0] r_cup_thresh;
    logic [TIME_BITS-1:0]   r_lift_tmo;
    logic [DELTA_BITS-1:0]  r_min_delta;
    logic [DELTA_BITS-1:0]  r_max_delta;

    // Tracking state.
    t_mode                         r_mode, n_mode;
    logic signed [WEIGHT_BITS-1:0] r_ref_weight, n_ref_weight;
    logic                          r_lifted, n_lifted;
    logic [TIME_BITS-1:0]          r_lift_time, n_lift_time;

    // Input register.
    logic                          r_in_valid;
    logic signed [WEIGHT_BITS-1:0] r_in_weight;
    logic                          r_in_settled;
    logic signed [WEIGHT_BITS-1:0] r_in_settled_weight;
    logic [TIME_BITS-1:0]          r_in_now;

    // Output register.
    logic                          r_out_valid;
    logic [KIND_BITS-1:0]          r_out_kind, n_kind;
    logic signed [AMOUNT_BITS-1:0] r_out_amount, n_amount;
    logic [MODE_BITS-1:0]          r_out_mode;

    logic                          advance;
    logic                          accept;
    logic signed [CW-1:0]          weight_cmp;
    logic signed [CW-1:0]          thresh_cmp;
    logic                          present;
    logic signed [DW-1:0]          drop;
    logic signed [DW-1:0]          rise;
    logic signed [DW-1:0]          min_cmp;
    logic signed [DW-1:0]          max_cmp;
    logic signed [DW-1:0]          amax_cmp;
    logic [TIME_BITS-1:0]          elapsed;

    // Flow control: the input register moves on when the output register is free.
    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready = !r_in_valid || !r_out_valid || o_result.ready;
    assign accept         = i_sample.valid && i_sample.ready;

    // Presence test and delta arithmetic.
    assign weight_cmp = CW'(r_in_weight);
    assign thresh_cmp = CW'($signed({1'b0, r_cup_thresh}));
    assign present    = weight_cmp >= thresh_cmp;
    assign drop       = DW'(r_ref_weight) - DW'(r_in_settled_weight);
    assign rise       = -drop;
    assign min_cmp    = DW'($signed({1'b0, r_min_delta}));
    assign max_cmp    = DW'($signed({1'b0, r_max_delta}));
    assign amax_cmp   = DW'($signed({1'b0, AMOUNT_MAX}));
    assign elapsed    = r_in_now - r_lift_time;

    // Mode update for the sample in the input register.
    always_comb begin
        n_mode       = r_mode;
        n_ref_weight = r_ref_weight;
        n_lifted     = r_lifted;
        n_lift_time  = r_lift_time;
        n_kind       = EVT_NONE;
        n_amount     = '0;
        unique case (r_mode)
            MODE_NO_CUP: begin
                if (r_lifted && (elapsed > r_lift_tmo)) begin
                    n_lifted = 1'b0;
                end
                if (present) begin
                    n_mode = MODE_UNSTABLE;
                end
            end
            MODE_UNSTABLE: begin
                if (!present) begin
                    n_mode = MODE_NO_CUP;
                end else if (r_in_settled) begin
                    n_ref_weight = r_in_settled_weight;
                    n_mode       = MODE_STABLE;
                    if (r_lifted) begin
                        n_lifted = 1'b0;
                        if ((drop >= min_cmp) && (drop <= max_cmp)) begin
                            n_kind   = EVT_DRINK;
                            n_amount = drop[AMOUNT_BITS-1:0];
                            n_mode   = MODE_DRINK;
                        end else if (rise >= min_cmp) begin
                            n_kind   = EVT_REFILL;
                            n_amount = (rise > amax_cmp) ? AMOUNT_MAX
                                                         : rise[AMOUNT_BITS-1:0];
                            n_mode   = MODE_REFILL;
                        end
                    end
                end
            end
            MODE_STABLE, MODE_POSSIBLE: begin
                if (!present) begin
                    n_lifted    = 1'b1;
                    n_lift_time = r_in_now;
                    n_mode      = MODE_NO_CUP;
                end else if (r_mode == MODE_STABLE) begin
                    if (!r_in_settled) begin
                        n_mode = MODE_POSSIBLE;
                    end
                end else if (r_in_settled) begin
                    n_ref_weight = r_in_settled_weight;
                    n_mode       = MODE_STABLE;
                end
            end
            default: begin
                // Drink, refill and unused codes all re-reference and settle.
                n_ref_weight = r_in_settled_weight;
                n_mode       = MODE_STABLE;
            end
        endcase
    end

    // State, configuration, input and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cup_thresh <= RST_CUP_THRESH;
            r_lift_tmo   <= RST_LIFT_TMO;
            r_min_delta  <= RST_MIN_DELTA;
            r_max_delta  <= RST_MAX_DELTA;
            r_mode       <= MODE_NO_CUP;
            r_ref_weight <= '0;
            r_lifted     <= 1'b0;
            r_lift_time  <= '0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CUP_THRESH: r_cup_thresh <= i_cfg_data[THRESH_BITS-1:0];
                    CFG_LIFT_TMO:   r_lift_tmo   <= i_cfg_data[TIME_BITS-1:0];
                    CFG_MIN_DELTA:  r_min_delta  <= i_cfg_data[DELTA_BITS-1:0];
                    CFG_MAX_DELTA:  r_max_delta  <= i_cfg_data[DELTA_BITS-1:0];
                    default: ;
                endcase
            end
            if (advance) begin
                r_mode       <= n_mode;
                r_ref_weight <= n_ref_weight;
                r_lifted     <= n_lifted;
                r_lift_time  <= n_lift_time;
            end
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_weight         <= i_sample.weight_now;
            r_in_settled        <= i_sample.scale_settled;
            r_in_settled_weight <= i_sample.settled_weight;
            r_in_now            <= i_sample.now_ms;
        end
        if (advance) begin
            r_out_kind   <= n_kind;
            r_out_amount <= n_amount;
            r_out_mode   <= n_mode;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.event_kind   = r_out_kind;
    assign o_result.event_amount = r_out_amount;
    assign o_result.mode_now     = r_out_mode;

endmodule

[rtl/cwdd_checker.sv]
module cwdd_checker
    import cwdd_pkg::*;
(
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [KIND_BITS-1:0]          i_res_kind,
    input logic signed [AMOUNT_BITS-1:0] i_res_amount,
    input logic [MODE_BITS-1:0]          i_res_mode
);

    // A result with no event carries a zero amount.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && (i_res_kind == EVT_NONE)) |-> (i_res_amount == '0))
        else $error("event-free result carries a non-zero amount");

    // A drink is reported together with the drink mode.
    a_drink_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && (i_res_kind == EVT_DRINK)) |-> (i_res_mode == MODE_CODE_DRINK))
        else $error("drink event without drink mode");

    // A refill is reported together with the refill mode.
    a_refill_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && (i_res_kind == EVT_REFILL)) |-> (i_res_mode == MODE_CODE_REFILL))
        else $error("refill event without refill mode");

    // Reported amounts are magnitudes and never negative.
    a_amount_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !i_res_amount[AMOUNT_BITS-1])
        else $error("negative event amount");

    // A stalled result transaction stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> i_res_valid)
        else $error("result withdrawn while stalled");

endmodule

bind cup_weight_drink_detector_unit cwdd_checker u_cwdd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_result.valid),
    .i_res_ready  (o_result.ready),
    .i_res_kind   (o_result.event_kind),
    .i_res_amount (o_result.event_amount),
    .i_res_mode   (o_result.mode_now)
);
